// ===== hw/rtl/sha256_pkg.sv =====
// Shared types and constants for the SHA-256 hash core.
package sha256_pkg;

  // Working variables a..h, index 0 is a.
  typedef logic [7:0][31:0] wvars_t;

  // Sixteen-word block buffer / schedule window, index 15 is the oldest word.
  typedef logic [15:0][31:0] blk_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_FIN
  } state_t;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

  localparam wvars_t INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// ===== hw/rtl/sha256_hash_core.sv =====
// SHA-256 hash core: byte stream in, 256-bit digest out, one shared round unit.
// Flow: bytes are taken only in idle; a byte that completes a 64-byte block starts a
//   compression (64 rounds of the single round unit, then the chain add).
// End of message: 1..64 padding bytes and one length step, plus one or two compressions;
//   the final chain add registers the digest on out_*, waiting while the last is unclaimed.
// Reset (rst_n low, synchronous) loads the initial hash, clears length and control.
module sha256_hash_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tuser,   // byte_present
  input  logic         in_tlast,   // end_of_message
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [255:0] out_tdata   // digest_word_0 [31:0] .. digest_word_7 [255:224]
);

  sha256_pkg::state_t state_r, state_nxt;
  sha256_pkg::wvars_t chain_r, chain_nxt;    // chaining value H0..H7
  sha256_pkg::wvars_t wv_r, wv_nxt;          // a..h
  sha256_pkg::wvars_t digest_r, digest_nxt;
  sha256_pkg::wvars_t wv_rnd, sums;
  sha256_pkg::blk_t   blk_r, blk_nxt;        // block buffer, doubles as schedule window
  logic [511:0]       blk_flat;
  logic [63:0]        count_r, count_nxt;    // message length in bits, wraps
  logic [5:0]         fill_r, fill_nxt;      // bytes in the current block
  logic [5:0]         rnd_r, rnd_nxt;
  logic               sent80_r, sent80_nxt;  // pad byte already inserted
  logic               pad_r, pad_nxt;        // padding in progress
  logic               final_r, final_nxt;    // last compression of the message
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        wnew;
  logic [7:0]         pad_byte;

  assign blk_flat   = blk_r;
  assign in_tready  = (state_r == sha256_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = digest_r;
  assign pad_byte   = sent80_r ? 8'h00 : sha256_pkg::PAD_BYTE;

  sha256_round u_round (
    .wv_i   (wv_r),
    .k_i    (sha256_pkg::ROUND_K[rnd_r]),
    .win_i  (blk_r),
    .wv_o   (wv_rnd),
    .wnew_o (wnew)
  );

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sums[i] = chain_r[i] + wv_r[i];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    chain_nxt     = chain_r;
    wv_nxt        = wv_r;
    digest_nxt    = digest_r;
    blk_nxt       = blk_r;
    count_nxt     = count_r;
    fill_nxt      = fill_r;
    rnd_nxt       = rnd_r;
    sent80_nxt    = sent80_r;
    pad_nxt       = pad_r;
    final_nxt     = final_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      sha256_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser) begin
            blk_nxt   = {blk_flat[503:0], in_tdata};
            count_nxt = count_r + 64'd8;
            fill_nxt  = fill_r + 6'd1;
            if (fill_r == 6'd63) begin
              // block full: compress, then pad if this request also ends the message
              state_nxt = sha256_pkg::ST_COMP;
              wv_nxt    = chain_r;
              rnd_nxt   = '0;
              pad_nxt   = in_tlast;
            end else if (in_tlast) begin
              state_nxt = sha256_pkg::ST_PAD;
              pad_nxt   = 1'b1;
            end
          end else if (in_tlast) begin
            state_nxt = sha256_pkg::ST_PAD;
            pad_nxt   = 1'b1;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        blk_nxt    = {blk_flat[503:0], pad_byte};
        sent80_nxt = 1'b1;
        fill_nxt   = fill_r + 6'd1;
        if (fill_r == 6'd63) begin
          state_nxt = sha256_pkg::ST_COMP;
          wv_nxt    = chain_r;
          rnd_nxt   = '0;
        end else if (fill_r == sha256_pkg::LEN_OFFSET - 6'd1) begin
          state_nxt = sha256_pkg::ST_LEN;
        end
      end
      sha256_pkg::ST_LEN: begin
        blk_nxt   = {blk_flat[447:0], count_r};
        fill_nxt  = '0;
        final_nxt = 1'b1;
        state_nxt = sha256_pkg::ST_COMP;
        wv_nxt    = chain_r;
        rnd_nxt   = '0;
      end
      sha256_pkg::ST_COMP: begin
        wv_nxt  = wv_rnd;
        blk_nxt = {blk_r[14:0], wnew};
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = sha256_pkg::ST_FIN;
        end
      end
      sha256_pkg::ST_FIN: begin
        if (final_r) begin
          // hold here while the previous digest is still unclaimed
          if (!out_valid_r || out_tready) begin
            digest_nxt    = sums;
            out_valid_nxt = 1'b1;
            chain_nxt     = sha256_pkg::INIT_HASH;
            count_nxt     = '0;
            sent80_nxt    = 1'b0;
            pad_nxt       = 1'b0;
            final_nxt     = 1'b0;
            state_nxt     = sha256_pkg::ST_IDLE;
          end
        end else begin
          chain_nxt = sums;
          state_nxt = pad_r ? sha256_pkg::ST_PAD : sha256_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sha256_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha256_pkg::ST_IDLE;
      chain_r     <= sha256_pkg::INIT_HASH;
      count_r     <= '0;
      fill_r      <= '0;
      rnd_r       <= '0;
      sent80_r    <= 1'b0;
      pad_r       <= 1'b0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chain_r     <= chain_nxt;
      count_r     <= count_nxt;
      fill_r      <= fill_nxt;
      rnd_r       <= rnd_nxt;
      sent80_r    <= sent80_nxt;
      pad_r       <= pad_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wv_r     <= wv_nxt;
    blk_r    <= blk_nxt;
    digest_r <= digest_nxt;
  end

  // last round always hands over to the chain add
  a_rnd_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha256_pkg::ST_COMP && rnd_r == 6'd63) |=> (state_r == sha256_pkg::ST_FIN))
    else $error("round counter did not end compression");

  // length words always land at bytes 56..63
  a_len_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha256_pkg::ST_LEN) |-> (fill_r == sha256_pkg::LEN_OFFSET))
    else $error("length inserted at wrong block offset");

  // a byte that fills the block starts a compression
  a_full_comp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser && fill_r == 6'd63)
      |=> (state_r == sha256_pkg::ST_COMP && rnd_r == 6'd0))
    else $error("full block not compressed");

  // final compression always works on a freshly closed block
  a_final_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha256_pkg::ST_FIN && final_r) |-> (fill_r == 6'd0 && sent80_r))
    else $error("final compression without padding");

endmodule

// ===== hw/rtl/sha256_round.sv =====
// One SHA-256 compression round plus one message schedule step.
module sha256_round (
  input  sha256_pkg::wvars_t wv_i,     // a..h before the round
  input  logic [31:0]        k_i,      // round constant
  input  sha256_pkg::blk_t   win_i,    // schedule window, [15] is W[t]
  output sha256_pkg::wvars_t wv_o,     // a..h after the round
  output logic [31:0]        wnew_o    // W[t+16]
);

  function automatic logic [31:0] rotr(input logic [31:0] v, input int k);
    rotr = (v >> k) | (v << (32 - k));
  endfunction

  logic [31:0] big0, big1, ch, mj, t1, t2, s0, s1;

  always_comb begin
    big1 = rotr(wv_i[4], 6) ^ rotr(wv_i[4], 11) ^ rotr(wv_i[4], 25);
    ch   = (wv_i[4] & wv_i[5]) ^ (~wv_i[4] & wv_i[6]);
    t1   = wv_i[7] + big1 + ch + k_i + win_i[15];
    big0 = rotr(wv_i[0], 2) ^ rotr(wv_i[0], 13) ^ rotr(wv_i[0], 22);
    mj   = (wv_i[0] & wv_i[1]) ^ (wv_i[0] & wv_i[2]) ^ (wv_i[1] & wv_i[2]);
    t2   = big0 + mj;

    wv_o[7] = wv_i[6];
    wv_o[6] = wv_i[5];
    wv_o[5] = wv_i[4];
    wv_o[4] = wv_i[3] + t1;
    wv_o[3] = wv_i[2];
    wv_o[2] = wv_i[1];
    wv_o[1] = wv_i[0];
    wv_o[0] = t1 + t2;

    // W[t+16] = s1(W[t+14]) + W[t+9] + s0(W[t+1]) + W[t]
    s0 = rotr(win_i[14], 7) ^ rotr(win_i[14], 18) ^ (win_i[14] >> 3);
    s1 = rotr(win_i[1], 17) ^ rotr(win_i[1], 19) ^ (win_i[1] >> 10);
    wnew_o = win_i[15] + s0 + win_i[6] + s1;
  end

endmodule
